### rtl/core/blf_pkg.sv
// Package for the battery level filter: level codes, register indexes,
// the configuration bundle and the reciprocal table for the smoothing weight.
// No dependencies.
package blf_pkg;

  // Field widths
  localparam int MvW        = 16;
  localparam int AlphaW     = 7;
  localparam int CfgAddrW   = 2;

  // Fixed-point reciprocal of the weight: step = (|diff| * recip) >> RecipShift.
  // 2**23 > 100 * 2**16 keeps the truncated quotient exact for 16-bit diffs.
  localparam int RecipShift = 23;
  localparam int RecipW     = RecipShift + 1;
  localparam int ProdW      = MvW + RecipW;

  localparam int PercentScale = 100;
  localparam int AlphaMin     = 1;
  localparam int AlphaDepth   = 1 << AlphaW;

  // Battery classes
  typedef enum logic [1:0] {
    LVL_UNKNOWN  = 2'd0,
    LVL_NORMAL   = 2'd1,
    LVL_LOW      = 2'd2,
    LVL_CRITICAL = 2'd3
  } level_t;

  // Register indexes on the config port
  typedef enum logic [CfgAddrW-1:0] {
    REG_FILTER_PERCENT = 2'd0,
    REG_CRITICAL_LIMIT = 2'd1,
    REG_LOW_LIMIT      = 2'd2,
    REG_HYSTERESIS     = 2'd3
  } cfg_reg_t;

  // Reset values
  localparam logic [AlphaW-1:0] FILTER_PERCENT_RST = 7'd20;
  localparam logic [MvW-1:0]    CRITICAL_LIMIT_RST = 16'd3300;
  localparam logic [MvW-1:0]    LOW_LIMIT_RST      = 16'd3500;
  localparam logic [MvW-1:0]    HYSTERESIS_RST     = 16'd100;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [RecipW-1:0] recip;
    logic [MvW-1:0]    crit_mv;
    logic [MvW-1:0]    low_mv;
    logic [MvW-1:0]    hyst_mv;
  } cfg_t;

  typedef logic [RecipW-1:0] recip_tab_t [0:AlphaDepth-1];

  // ceil(alpha * 2**RecipShift / 100) with alpha clamped to 1..100;
  // evaluated at elaboration only.
  function automatic recip_tab_t build_recip_tab();
    recip_tab_t tab;
    longint     a;
    for (int i = 0; i < AlphaDepth; i++) begin
      a = longint'(i);
      if (a < AlphaMin) a = AlphaMin;
      if (a > PercentScale) a = PercentScale;
      tab[i] = RecipW'(((a << RecipShift) + PercentScale - 1) / PercentScale);
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TAB = build_recip_tab();

endpackage

### rtl/core/blf_cfg_regs.sv
// Configuration register bank of the battery level filter.
// Converts the weight to its fixed-point reciprocal at write time.
// Depends on blf_pkg.
module blf_cfg_regs
  import blf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [MvW-1:0]      cfg_wdata,
  output cfg_t                cfg
);

  logic [RecipW-1:0] recip_r;
  logic [MvW-1:0]    crit_r;
  logic [MvW-1:0]    low_r;
  logic [MvW-1:0]    hyst_r;

  // Register writes; weight goes through the reciprocal table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recip_r <= RECIP_TAB[FILTER_PERCENT_RST];
      crit_r  <= CRITICAL_LIMIT_RST;
      low_r   <= LOW_LIMIT_RST;
      hyst_r  <= HYSTERESIS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FILTER_PERCENT: recip_r <= RECIP_TAB[cfg_wdata[AlphaW-1:0]];
        REG_CRITICAL_LIMIT: crit_r  <= cfg_wdata;
        REG_LOW_LIMIT:      low_r   <= cfg_wdata;
        REG_HYSTERESIS:     hyst_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.recip   = recip_r;
  assign cfg.crit_mv = crit_r;
  assign cfg.low_mv  = low_r;
  assign cfg.hyst_mv = hyst_r;

endmodule

### rtl/core/blf_ema.sv
// Moving-average update: seed on first sample, else move by
// |diff| * alpha / 100 (truncated toward zero). Depends on blf_pkg.
module blf_ema
  import blf_pkg::*;
(
  input  logic [MvW-1:0]    raw_mv,
  input  logic [MvW-1:0]    smoothed_mv,
  input  logic [RecipW-1:0] recip,
  output logic [MvW-1:0]    next_mv
);

  logic             seed;
  logic             up;
  logic [MvW-1:0]   mag;
  logic [ProdW-1:0] prod;
  logic [MvW-1:0]   step;

  // Work on the magnitude so truncation is toward zero in both directions
  always_comb begin
    seed = (smoothed_mv == '0);
    up   = (raw_mv >= smoothed_mv);
    mag  = up ? (raw_mv - smoothed_mv) : (smoothed_mv - raw_mv);
    prod = ProdW'(mag) * ProdW'(recip);
    step = prod[RecipShift +: MvW];
    if (seed) begin
      next_mv = raw_mv;
    end else if (up) begin
      next_mv = smoothed_mv + step;
    end else begin
      next_mv = smoothed_mv - step;
    end
  end

endmodule

### rtl/core/blf_classify.sv
// Four-state level classifier with hysteresis on leaving Low and Critical.
// Depends on blf_pkg.
module blf_classify
  import blf_pkg::*;
(
  input  logic [MvW-1:0] filt_mv,
  input  level_t         cur_level,
  input  cfg_t           cfg,
  output level_t         next_level
);

  logic [MvW:0] f_ext;
  logic [MvW:0] crit_exit;
  logic [MvW:0] low_exit;
  logic         at_crit;
  logic         at_low;

  // 17-bit thresholds so limit + margin never wraps
  always_comb begin
    f_ext     = {1'b0, filt_mv};
    crit_exit = {1'b0, cfg.crit_mv} + {1'b0, cfg.hyst_mv};
    low_exit  = {1'b0, cfg.low_mv} + {1'b0, cfg.hyst_mv};
    at_crit   = (filt_mv <= cfg.crit_mv);
    at_low    = (filt_mv <= cfg.low_mv);
  end

  always_comb begin
    unique case (cur_level)
      LVL_CRITICAL: begin
        if (f_ext >= crit_exit) begin
          next_level = at_low ? LVL_LOW : LVL_NORMAL;
        end else begin
          next_level = LVL_CRITICAL;
        end
      end
      LVL_LOW: begin
        if (at_crit) begin
          next_level = LVL_CRITICAL;
        end else if (f_ext >= low_exit) begin
          next_level = LVL_NORMAL;
        end else begin
          next_level = LVL_LOW;
        end
      end
      default: begin
        if (at_crit) begin
          next_level = LVL_CRITICAL;
        end else if (at_low) begin
          next_level = LVL_LOW;
        end else begin
          next_level = LVL_NORMAL;
        end
      end
    endcase
  end

endmodule

### rtl/core/battery_level_filter_hysteresis.sv
// Battery level filter with hysteresis.
// Usage:
//   Input stream (in_*): one raw sample in millivolts per request; a zero
//   sample means no sample and reports the current state again.
//   Output stream (out_*): one request per input, carrying the battery
//   class and the filtered voltage after that sample.
//   Config port (cfg_*): 0 weight in percent, 1 critical limit,
//   2 low limit, 3 hysteresis margin; write only while the block is idle.
// Timing:
//   Input register, then the filter update and classifier feed the output
//   register. The filter state is the output register itself and is updated
//   as a request advances, so one request is taken every cycle while the
//   output is not stalled; the path is set by one 16x24 multiply plus the
//   threshold compares.
// Reset (rst_n low, synchronous): filter unseeded, class unknown,
//   registers back to 20 / 3300 / 3500 / 100, both streams empty.
// Stall: while out_tready is low the output holds; the input register
//   still takes one more request if it is empty, then in_tready drops.
// Depends on blf_pkg, blf_cfg_regs, blf_ema, blf_classify.
module battery_level_filter_hysteresis
  import blf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,   // [15:0] raw_mv
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // [1:0] level_class, [17:2] filtered_mv, rest 0
  // config port
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [MvW-1:0]      cfg_wdata
);

  cfg_t            cfg;
  logic            in_vld_r;
  logic [MvW-1:0]  sample_r;
  logic            out_vld_r;
  logic [MvW-1:0]  smoothed_r;
  logic [MvW-1:0]  smoothed_nxt;
  level_t          level_r;
  level_t          level_nxt;
  logic [MvW-1:0]  ema_mv;
  level_t          class_lvl;
  logic            out_free;
  logic            advance;
  logic            has_sample;

  blf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  blf_ema u_ema (
    .raw_mv      (sample_r),
    .smoothed_mv (smoothed_r),
    .recip       (cfg.recip),
    .next_mv     (ema_mv)
  );

  blf_classify u_class (
    .filt_mv    (ema_mv),
    .cur_level  (level_r),
    .cfg        (cfg),
    .next_level (class_lvl)
  );

  // Handshake: input register moves on whenever the output slot frees up
  assign out_free  = !out_vld_r || out_tready;
  assign advance   = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  // Zero sample leaves the state untouched
  always_comb begin
    has_sample   = (sample_r != '0);
    smoothed_nxt = has_sample ? ema_mv : smoothed_r;
    level_nxt    = has_sample ? class_lvl : level_r;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sample_r <= in_tdata;
    end
  end

  // Filter state, which doubles as the output payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      smoothed_r <= '0;
      level_r    <= LVL_UNKNOWN;
    end else begin
      if (out_free) begin
        out_vld_r <= in_vld_r;
      end
      if (advance) begin
        smoothed_r <= smoothed_nxt;
        level_r    <= level_nxt;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, smoothed_r, level_r};

endmodule

### tb/tb_battery_level_filter_hysteresis.sv
// Self-checking bench for battery_level_filter_hysteresis: a table of directed
// samples, then randomized phases, checked against a predictor of the filter.
// Depends on blf_pkg and the battery_level_filter_hysteresis RTL.
module tb_battery_level_filter_hysteresis;
  import blf_pkg::*;

  localparam int          NumPhases     = 12;
  localparam int          ItemsPerPhase = 103;
  localparam int          LongHold      = 64;
  localparam int unsigned CycleLimit    = 400000;
  localparam int          MaxPrinted    = 40;

  // Directed table rows: a register write or one sample request
  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    cfg_reg_t     reg_idx;
    logic [15:0]  value;
    logic         has_exp;
    level_t       lvl;
    logic [15:0]  mv;
  } dir_row_t;

  typedef struct packed {
    level_t       lvl;
    logic [15:0]  mv;
  } level_report_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [15:0]         in_tdata   = '0;    // [15:0] raw_mv
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [23:0]         out_tdata;          // [1:0] level_class, [17:2] filtered_mv
  logic                cfg_we     = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr   = '0;
  logic [MvW-1:0]      cfg_wdata  = '0;

  // Predictor state and its copy of the registers
  logic [15:0]         ema_mv;
  level_t              cur_level;
  logic [AlphaW-1:0]   alpha_pct;
  logic [15:0]         crit_mv;
  logic [15:0]         low_mv;
  logic [15:0]         hyst_mv;

  level_report_t       expected_reports[$];
  int                  error_count   = 0;
  int                  checked_count = 0;
  int                  sent_count    = 0;
  int unsigned         cycle_count   = 0;
  bit                  src_busy      = 1'b1;
  bit                  sink_busy     = 1'b1;
  bit                  long_hold_pending = 1'b0;

  // Directed table: hysteresis edges at the reset limits, alpha extremes,
  // zero samples, and both degenerate limit orderings.
  dir_row_t dir_rows [0:29] = '{
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd0,     1'b1, LVL_UNKNOWN,  16'd0},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd65535, 1'b1, LVL_NORMAL,   16'd65535},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd0,     1'b1, LVL_NORMAL,   16'd65535},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd1,     1'b0, LVL_UNKNOWN,  16'd0},
    '{ROW_WRITE,  REG_FILTER_PERCENT, 16'd100,   1'b0, LVL_UNKNOWN,  16'd0},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd3300,  1'b1, LVL_CRITICAL, 16'd3300},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd3399,  1'b1, LVL_CRITICAL, 16'd3399},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd3400,  1'b1, LVL_LOW,      16'd3400},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd3599,  1'b1, LVL_LOW,      16'd3599},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd3600,  1'b1, LVL_NORMAL,   16'd3600},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd3500,  1'b1, LVL_LOW,      16'd3500},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd3301,  1'b1, LVL_LOW,      16'd3301},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd3300,  1'b1, LVL_CRITICAL, 16'd3300},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd3600,  1'b1, LVL_NORMAL,   16'd3600},
    '{ROW_WRITE,  REG_FILTER_PERCENT, 16'd0,     1'b0, LVL_UNKNOWN,  16'd0},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd1,     1'b0, LVL_UNKNOWN,  16'd0},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd65535, 1'b0, LVL_UNKNOWN,  16'd0},
    '{ROW_WRITE,  REG_FILTER_PERCENT, 16'd127,   1'b0, LVL_UNKNOWN,  16'd0},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'h5555,  1'b1, LVL_NORMAL,   16'h5555},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'hAAAA,  1'b1, LVL_NORMAL,   16'hAAAA},
    '{ROW_WRITE,  REG_CRITICAL_LIMIT, 16'd65535, 1'b0, LVL_UNKNOWN,  16'd0},
    '{ROW_WRITE,  REG_LOW_LIMIT,      16'd0,     1'b0, LVL_UNKNOWN,  16'd0},
    '{ROW_WRITE,  REG_HYSTERESIS,     16'd65535, 1'b0, LVL_UNKNOWN,  16'd0},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd1,     1'b1, LVL_CRITICAL, 16'd1},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd65535, 1'b1, LVL_CRITICAL, 16'd65535},
    '{ROW_WRITE,  REG_CRITICAL_LIMIT, 16'd0,     1'b0, LVL_UNKNOWN,  16'd0},
    '{ROW_WRITE,  REG_LOW_LIMIT,      16'd65535, 1'b0, LVL_UNKNOWN,  16'd0},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'h8000,  1'b1, LVL_CRITICAL, 16'h8000},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd65535, 1'b1, LVL_LOW,      16'd65535},
    '{ROW_SAMPLE, REG_FILTER_PERCENT, 16'd1,     1'b1, LVL_LOW,      16'd1}
  };

  battery_level_filter_hysteresis i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_reports.size());
      $display("** battery_level_filter_hysteresis: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MaxPrinted) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Next level class from the filtered value; limit sums kept at 17 bits
  function automatic level_t next_level(input logic [15:0] f, input level_t cur);
    logic [16:0] crit_exit;
    logic [16:0] low_exit;
    crit_exit = {1'b0, crit_mv} + {1'b0, hyst_mv};
    low_exit  = {1'b0, low_mv} + {1'b0, hyst_mv};
    if (cur == LVL_CRITICAL) begin
      if ({1'b0, f} >= crit_exit) return (f <= low_mv) ? LVL_LOW : LVL_NORMAL;
      return LVL_CRITICAL;
    end
    if (cur == LVL_LOW) begin
      if (f <= crit_mv) return LVL_CRITICAL;
      if ({1'b0, f} >= low_exit) return LVL_NORMAL;
      return LVL_LOW;
    end
    if (f <= crit_mv) return LVL_CRITICAL;
    if (f <= low_mv) return LVL_LOW;
    return LVL_NORMAL;
  endfunction

  // Moving average update plus classification for one accepted sample
  function automatic void track_sample(input logic [15:0] s);
    int weight;
    int diff;
    int nxt;
    if (s == '0) return;
    if (ema_mv == '0) begin
      ema_mv = s;
    end else begin
      weight = int'(alpha_pct);
      if (weight < AlphaMin) weight = AlphaMin;
      if (weight > PercentScale) weight = PercentScale;
      diff   = int'(s) - int'(ema_mv);
      nxt    = int'(ema_mv) + (diff * weight) / PercentScale;  // truncates toward zero
      ema_mv = nxt[15:0];
    end
    cur_level = next_level(ema_mv, cur_level);
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Samples cluster around the limits and their exit points so the
  // filtered value crosses them in both directions.
  function automatic logic [15:0] next_sample();
    int r;
    int center;
    int span;
    int v;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 25) return 16'($urandom_range(1, 65535));
    if (r < 30) return ($urandom_range(0, 1) != 0) ? 16'd1 : 16'hFFFF;
    case ($urandom_range(0, 3))
      0: center = int'(crit_mv);
      1: center = int'(low_mv);
      2: center = int'(crit_mv) + int'(hyst_mv);
      default: center = int'(low_mv) + int'(hyst_mv);
    endcase
    span = ((hyst_mv > 16'd400) ? 400 : int'(hyst_mv)) + 60;
    v = center + int'($urandom_range(0, 2 * span)) - span;
    if (v < 1) v = 1;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // One sample request; the expectation is queued at acceptance
  task automatic push_sample(input logic [15:0] s, input logic has_exp,
                             input level_t lvl, input logic [15:0] mv);
    int gap;
    gap = src_busy ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    track_sample(s);
    sent_count++;
    if (has_exp) expected_reports.push_back('{lvl, mv});
    else         expected_reports.push_back('{cur_level, ema_mv});
  endtask

  // Drain all results, then let the pipeline go idle before returning
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FILTER_PERCENT: alpha_pct = v[AlphaW-1:0];
      REG_CRITICAL_LIMIT: crit_mv   = v;
      REG_LOW_LIMIT:      low_mv    = v;
      REG_HYSTERESIS:     hyst_mv   = v;
      default: ;
    endcase
  endtask

  // Receiver pacing, with one long hold-off on request
  initial begin : sink_pacing
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (sink_busy) stall = pick_gap();
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : result_check
    level_report_t exp_rep;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_tdata));
      end else begin
        exp_rep = expected_reports.pop_front();
        checked_count++;
        if (out_tdata[1:0] != exp_rep.lvl)
          report_mismatch($sformatf("level_class %0d, expected %0d (result %0d)",
                                    out_tdata[1:0], exp_rep.lvl, checked_count));
        if (out_tdata[17:2] != exp_rep.mv)
          report_mismatch($sformatf("filtered_mv %0d, expected %0d (result %0d)",
                                    out_tdata[17:2], exp_rep.mv, checked_count));
        if (out_tdata[23:18] != '0)
          report_mismatch($sformatf("pad bits %h not zero", out_tdata[23:18]));
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    int fp;
    int crit;
    int low;
    int hyst;
    ema_mv    = '0;
    cur_level = LVL_UNKNOWN;
    alpha_pct = FILTER_PERCENT_RST;
    crit_mv   = CRITICAL_LIMIT_RST;
    low_mv    = LOW_LIMIT_RST;
    hyst_mv   = HYSTERESIS_RST;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        push_sample(dir_rows[i].value, dir_rows[i].has_exp, dir_rows[i].lvl, dir_rows[i].mv);
      end
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NumPhases; ph++) begin
      fp   = $urandom_range(1, 100);
      crit = $urandom_range(0, 40000);
      low  = crit + $urandom_range(0, 20000);
      hyst = $urandom_range(0, 5000);
      case (ph)
        0: begin
          fp = 20; crit = 3300; low = 3500; hyst = 100;
        end
        1: begin
          fp = 0; crit = $urandom_range(1000, 3000); low = crit + $urandom_range(0, 800);
          hyst = $urandom_range(1, 300);
        end
        2: begin
          fp = 100; hyst = 0;
        end
        3: fp = $urandom_range(101, 127);
        4: begin
          crit = 0; low = 65535; hyst = 65535;
        end
        5: begin
          // critical limit above the low limit
          crit = $urandom_range(20000, 60000); low = $urandom_range(0, crit - 1);
        end
        6: begin
          fp = $urandom_range(0, 65535);  // upper bits beyond the register are dropped
          hyst = $urandom_range(30000, 65535);
        end
        7: begin
          crit = 65535; low = 65535; hyst = $urandom_range(0, 65535);
        end
        default: ;
      endcase
      wait_idle();
      write_reg(REG_FILTER_PERCENT, 16'(fp));
      write_reg(REG_CRITICAL_LIMIT, 16'(crit));
      write_reg(REG_LOW_LIMIT, 16'(low > 65535 ? 65535 : low));
      write_reg(REG_HYSTERESIS, 16'(hyst));

      src_busy  = (ph % 3) != 1;
      sink_busy = (ph % 4) != 2;
      // receiver holds off while the sender keeps offering
      if (ph == 3) begin
        src_busy = 1'b0;
        long_hold_pending = 1'b1;
      end
      for (int n = 0; n < ItemsPerPhase; n++) push_sample(next_sample(), 1'b0, LVL_UNKNOWN, '0);
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (expected_reports.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_reports.size()));

    $display("Sent %0d sample requests across %0d register settings plus the directed table.",
             sent_count, NumPhases);
    $display("Checked %0d results; %0d mismatches.", checked_count, error_count);
    if (error_count == 0) begin
      $display("** battery_level_filter_hysteresis: PASSED **");
    end else begin
      $display("** battery_level_filter_hysteresis: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/blf_pkg.sv
rtl/core/blf_cfg_regs.sv
rtl/core/blf_ema.sv
rtl/core/blf_classify.sv
rtl/core/battery_level_filter_hysteresis.sv
tb/tb_battery_level_filter_hysteresis.sv
